// ===== hdl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg: shared constants and types of the Sobel edge magnitude core
// Line store geometry, field widths, register map and controller states.
// ----------------------------------------------------------------------------
package sem_pkg;

  // Line store geometry
  localparam int MaxWidth = 1024;
  localparam int AddrW    = $clog2(MaxWidth);

  // Field widths
  localparam int ChanW = 8;
  localparam int PixW  = 3 * ChanW;
  localparam int RowW  = 12;
  localparam int ColW  = 10;
  localparam int CfgWW = 11;
  localparam int CfgHW = 12;

  // Register map: byte address 4*i, index taken from paddr[2]
  localparam int AddrBits = 3;
  localparam int DataW    = 32;
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // Register reset values
  localparam logic [CfgWW-1:0] WidthReset  = CfgWW'(640);
  localparam logic [CfgHW-1:0] HeightReset = CfgHW'(480);

  // Magnitude clamp: 255 squared
  localparam int SatLevel = 65025;

  // Controller states
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StCalc   = 5'b00010,
    StSquare = 5'b00100,
    StRoot   = 5'b01000,
    StEmit   = 5'b10000
  } sem_state_e;

endpackage

// ===== hdl/sem_pix_if.sv =====
// ----------------------------------------------------------------------------
// sem_pix_if: incoming pixel channel
// Valid/ready handshake carrying one RGB pixel per request.
// ----------------------------------------------------------------------------
interface sem_pix_if;
  logic                     valid;
  logic                     ready;
  logic [sem_pkg::ChanW-1:0] in_red;
  logic [sem_pkg::ChanW-1:0] in_green;
  logic [sem_pkg::ChanW-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

// ===== hdl/sem_res_if.sv =====
// ----------------------------------------------------------------------------
// sem_res_if: outgoing result channel
// Valid/ready handshake carrying one tagged RGB pixel per request.
// ----------------------------------------------------------------------------
interface sem_res_if;
  logic                      valid;
  logic                      ready;
  logic [sem_pkg::ChanW-1:0] out_red;
  logic [sem_pkg::ChanW-1:0] out_green;
  logic [sem_pkg::ChanW-1:0] out_blue;
  logic [sem_pkg::RowW-1:0]  out_row;
  logic [sem_pkg::ColW-1:0]  out_col;
  logic                      last_of_run;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output last_of_run, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_col, input last_of_run, output ready);
endinterface

// ===== hdl/sobel_edge_magnitude_core.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_core: streaming 3x3 Sobel edge magnitude
// Red channel Sobel magnitude over a row-major RGB raster, border passthrough.
// ----------------------------------------------------------------------------
// Pixels enter one request at a time in row-major order; each interior pixel
// leaves as min(floor(sqrt(gx^2+gy^2)),255) on all three channels, border
// pixels leave unchanged, every result tagged with its row and column, one
// row and one column behind the input, last-row pixels as they arrive. Two
// line stores (one RAM each, one read and one write per pixel) hold the two
// earlier rows. Each pixel passes through the line store read, the kernel
// sums, the squares and the eight-step bit-per-cycle square root, then each
// result goes into the output register, one per free output slot, waiting
// while the output is stalled. The next pixel is taken while the last result
// still waits there.
// image_width sits at byte address 0, image_height at 4.
module sobel_edge_magnitude_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sem_pix_if.sink                         pix_i,
  sem_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sem_pkg::AddrBits-1:0]    paddr,
  input  logic [sem_pkg::DataW-1:0]       pwdata,
  output logic [sem_pkg::DataW-1:0]       prdata,
  output logic                            pready
);

  localparam int PW = sem_pkg::PixW;
  localparam int CW = sem_pkg::ChanW;
  localparam int RW = sem_pkg::RowW;
  localparam int KW = sem_pkg::ColW;

  // Registers
  sem_pkg::sem_state_e state_q, state_d;
  logic [sem_pkg::CfgWW-1:0] cfg_width_q;
  logic [sem_pkg::CfgHW-1:0] cfg_height_q;
  logic [RW-1:0] row_q, row_d;
  logic [KW-1:0] col_q, col_d;
  logic [PW-1:0] win_q [6];
  logic [PW-1:0] win_d [6];
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] pix0_q, pix0_d;
  logic [PW-1:0] pix1_q, pix1_d;
  logic          inner_q, inner_d;
  logic [2:0]    pend_q, pend_d;
  logic [RW-1:0] rtag_q, rtag_d;
  logic [KW-1:0] ctag_q, ctag_d;
  logic signed [10:0] gx_q, gx_d, gy_q, gy_d;
  logic          sat_q, sat_d;
  logic [15:0]   sqn_q, sqn_d;
  logic [CW-1:0] root_q, root_d;
  logic [2:0]    bit_q, bit_d;
  logic          ov_q, ov_d;
  logic [PW-1:0] opix_q, opix_d;
  logic [RW-1:0] orow_q, orow_d;
  logic [KW-1:0] ocol_q, ocol_d;
  logic          olast_q, olast_d;

  // Line store ports
  logic [PW-1:0] up2, up1;
  logic          ls_we;
  logic [sem_pkg::AddrW-1:0] ls_addr;

  // Combinational helpers
  logic [sem_pkg::CfgWW-1:0] weff;
  logic [sem_pkg::CfgHW-1:0] heff;
  logic last_col, last_row, interior;
  logic [9:0] sx_pos, sx_neg, sy_pos, sy_neg;
  logic [9:0] ax, ay;
  logic [20:0] sq_sum;
  logic [CW-1:0] trial;
  logic [15:0] trial_sq;
  logic [CW-1:0] mag;
  logic [2:0] pend_rest;
  logic in_take, out_free;

  // Line stores: rows r-2 and r-1
  assign ls_addr = sem_pkg::AddrW'(col_q);
  assign ls_we   = (state_q == sem_pkg::StCalc);

  sem_ram #(.Width(PW), .Depth(sem_pkg::MaxWidth)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_addr),
    .wdata_i (up1),
    .raddr_i (ls_addr),
    .rdata_o (up2)
  );

  sem_ram #(.Width(PW), .Depth(sem_pkg::MaxWidth)) u_prior_ram (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_addr),
    .wdata_i (cur_q),
    .raddr_i (ls_addr),
    .rdata_o (up1)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sem_pkg::RegHeight) ?
                  sem_pkg::DataW'(cfg_height_q) : sem_pkg::DataW'(cfg_width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= sem_pkg::WidthReset;
      cfg_height_q <= sem_pkg::HeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == sem_pkg::RegWidth) begin
        cfg_width_q <= pwdata[sem_pkg::CfgWW-1:0];
      end else begin
        cfg_height_q <= pwdata[sem_pkg::CfgHW-1:0];
      end
    end
  end

  // Clamp frame geometry
  always_comb begin
    if (cfg_width_q == '0) begin
      weff = sem_pkg::CfgWW'(1);
    end else if (cfg_width_q > sem_pkg::CfgWW'(sem_pkg::MaxWidth)) begin
      weff = sem_pkg::CfgWW'(sem_pkg::MaxWidth);
    end else begin
      weff = cfg_width_q;
    end
    heff = (cfg_height_q == '0) ? sem_pkg::CfgHW'(1) : cfg_height_q;
  end

  assign last_col = {1'b0, col_q} >= (weff - sem_pkg::CfgWW'(1));
  assign last_row = row_q >= (heff - sem_pkg::CfgHW'(1));
  assign interior = (row_q >= RW'(2)) && ({1'b0, row_q} + 13'd1 <= {1'b0, heff}) &&
                    (col_q >= KW'(2)) && ({1'b0, col_q} + 11'd1 <= weff);

  // Kernel sums on the red channel
  assign sx_pos = 10'(up2[23:16]) + {1'b0, up1[23:16], 1'b0} + 10'(cur_q[23:16]);
  assign sx_neg = 10'(win_q[3][23:16]) + {1'b0, win_q[4][23:16], 1'b0} +
                  10'(win_q[5][23:16]);
  assign sy_pos = 10'(win_q[5][23:16]) + {1'b0, win_q[2][23:16], 1'b0} +
                  10'(cur_q[23:16]);
  assign sy_neg = 10'(win_q[3][23:16]) + {1'b0, win_q[0][23:16], 1'b0} +
                  10'(up2[23:16]);

  // Squares of the gradient magnitudes, widened to the full sum width
  assign ax     = gx_q[10] ? 10'(-gx_q) : gx_q[9:0];
  assign ay     = gy_q[10] ? 10'(-gy_q) : gy_q[9:0];
  assign sq_sum = ({11'd0, ax} * {11'd0, ax}) + ({11'd0, ay} * {11'd0, ay});

  // One root bit per cycle
  assign trial    = root_q | (CW'(1) << bit_q);
  assign trial_sq = trial * trial;
  assign mag      = sat_q ? {CW{1'b1}} : root_q;

  // Handshake
  assign in_take  = pix_i.valid && (state_q == sem_pkg::StIdle);
  assign out_free = !ov_q || res_o.ready;
  assign pix_i.ready = (state_q == sem_pkg::StIdle);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    win_d   = win_q;
    cur_d   = cur_q;
    pix0_d  = pix0_q;
    pix1_d  = pix1_q;
    inner_d = inner_q;
    pend_d  = pend_q;
    rtag_d  = rtag_q;
    ctag_d  = ctag_q;
    gx_d    = gx_q;
    gy_d    = gy_q;
    sat_d   = sat_q;
    sqn_d   = sqn_q;
    root_d  = root_q;
    bit_d   = bit_q;
    ov_d    = ov_q && !res_o.ready;
    opix_d  = opix_q;
    orow_d  = orow_q;
    ocol_d  = ocol_q;
    olast_d = olast_q;
    pend_rest = pend_q;

    case (state_q)
      sem_pkg::StIdle: begin
        // Take the pixel; the line store read is issued at this edge
        if (in_take) begin
          cur_d   = {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
          state_d = sem_pkg::StCalc;
        end
      end
      sem_pkg::StCalc: begin
        // Form gradients, queue results, shift the window, advance position
        gx_d    = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
        gy_d    = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
        pix0_d  = win_q[1];
        pix1_d  = up1;
        inner_d = interior;
        rtag_d  = row_q;
        ctag_d  = col_q;
        pend_d  = {last_row, (row_q != '0) && last_col, (row_q != '0) && (col_q != '0)};
        win_d[3] = win_q[0];
        win_d[4] = win_q[1];
        win_d[5] = win_q[2];
        win_d[0] = up2;
        win_d[1] = up1;
        win_d[2] = cur_q;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + RW'(1);
        end else begin
          col_d = col_q + KW'(1);
        end
        state_d = sem_pkg::StSquare;
      end
      sem_pkg::StSquare: begin
        sat_d   = sq_sum >= 21'(sem_pkg::SatLevel);
        sqn_d   = sq_sum[15:0];
        root_d  = '0;
        bit_d   = 3'd7;
        state_d = sem_pkg::StRoot;
      end
      sem_pkg::StRoot: begin
        if (trial_sq <= sqn_q) begin
          root_d = trial;
        end
        bit_d = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          state_d = sem_pkg::StEmit;
        end
      end
      sem_pkg::StEmit: begin
        // Drain queued results in order, one per free output slot
        if (pend_q == '0) begin
          state_d = sem_pkg::StIdle;
        end else if (out_free) begin
          ov_d = 1'b1;
          if (pend_q[0]) begin
            pend_rest = {pend_q[2:1], 1'b0};
            opix_d    = inner_q ? {mag, mag, mag} : pix0_q;
            orow_d    = rtag_q - RW'(1);
            ocol_d    = ctag_q - KW'(1);
          end else if (pend_q[1]) begin
            pend_rest = {pend_q[2], 2'b00};
            opix_d    = pix1_q;
            orow_d    = rtag_q - RW'(1);
            ocol_d    = ctag_q;
          end else begin
            pend_rest = 3'b000;
            opix_d    = cur_q;
            orow_d    = rtag_q;
            ocol_d    = ctag_q;
          end
          olast_d = (pend_rest == '0);
          pend_d  = pend_rest;
          if (pend_rest == '0) begin
            state_d = sem_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = sem_pkg::StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::StIdle;
      row_q   <= '0;
      col_q   <= '0;
      pend_q  <= '0;
      ov_q    <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
      win_q   <= win_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    pix0_q  <= pix0_d;
    pix1_q  <= pix1_d;
    inner_q <= inner_d;
    rtag_q  <= rtag_d;
    ctag_q  <= ctag_d;
    gx_q    <= gx_d;
    gy_q    <= gy_d;
    sat_q   <= sat_d;
    sqn_q   <= sqn_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    opix_q  <= opix_d;
    orow_q  <= orow_d;
    ocol_q  <= ocol_d;
    olast_q <= olast_d;
  end

  // Result channel
  assign res_o.valid       = ov_q;
  assign res_o.out_red     = opix_q[23:16];
  assign res_o.out_green   = opix_q[15:8];
  assign res_o.out_blue    = opix_q[7:0];
  assign res_o.out_row     = orow_q;
  assign res_o.out_col     = ocol_q;
  assign res_o.last_of_run = olast_q;

endmodule

// ===== hdl/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read the array, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
